// File: rtl/spp_pkg.sv
// Shared constants for the sprite screen projection pipeline.
package spp_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // Widths of the front-end products and sums
    localparam int DX_W   = 17;
    localparam int PROD_W = 33;
    localparam int DPRD_W = 32;
    localparam int DET_W  = 33;
    localparam int NUM_W  = 34;

endpackage

// File: rtl/spp_div_cell.sv
// One restoring-division cell: resolves one quotient bit per cycle.
module spp_div_cell #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [NW-1:0] in_quot,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [NW-1:0] out_num,
    output logic [NW-1:0] out_quot,
    output logic [DW-1:0] out_den,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] quot_reg, quot_next;
    logic [DW-1:0] den_reg;
    logic [SW-1:0] side_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb
    begin
        trial     = {in_rem, in_num[NW-1]};
        diff      = trial - {1'b0, in_den};
        ge        = (trial >= {1'b0, in_den});
        rem_next  = ge ? diff[DW-1:0] : trial[DW-1:0];
        num_next  = {in_num[NW-2:0], 1'b0};
        quot_next = {in_quot[NW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= in_den;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_quot  = quot_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

// File: rtl/spp_div.sv
// Unsigned divider built as a chain of one-bit cells, one item per cycle.
module spp_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] quot,
    output logic [SW-1:0] out_side
);

    logic          v_w    [0:NW];
    logic [DW-1:0] rem_w  [0:NW];
    logic [NW-1:0] num_w  [0:NW];
    logic [NW-1:0] quot_w [0:NW];
    logic [DW-1:0] den_w  [0:NW];
    logic [SW-1:0] side_w [0:NW];

    assign v_w[0]    = in_valid;
    assign rem_w[0]  = '0;
    assign num_w[0]  = num;
    assign quot_w[0] = '0;
    assign den_w[0]  = den;
    assign side_w[0] = in_side;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        spp_div_cell #(
            .NW(NW),
            .DW(DW),
            .SW(SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (v_w[i]),
            .in_rem   (rem_w[i]),
            .in_num   (num_w[i]),
            .in_quot  (quot_w[i]),
            .in_den   (den_w[i]),
            .in_side  (side_w[i]),
            .out_valid(v_w[i+1]),
            .out_rem  (rem_w[i+1]),
            .out_num  (num_w[i+1]),
            .out_quot (quot_w[i+1]),
            .out_den  (den_w[i+1]),
            .out_side (side_w[i+1])
        );
    end

    assign out_valid = v_w[NW];
    assign quot      = quot_w[NW];
    assign out_side  = side_w[NW];

endmodule

// File: rtl/sprite_screen_projection_unit.sv
// Top level: fully pipelined sprite projection into screen space.
//
// One sprite is taken per clock. Its result is transferred on the result ports,
// marked by done, after it has passed the front-end stages, the two divider
// chains for the camera transform, the product stages, the two divider chains
// for the column and size (each 47 + VEC_FRAC_BITS cells) and the output
// register. busy is always low; the block never stalls and the receiver must
// take every result in its cycle. Screen width and height may be rewritten only
// while no sprite is in flight.
module sprite_screen_projection_unit
    import spp_pkg::*;
#(
    parameter int POS_FRAC_BITS = 8,
    parameter int VEC_FRAC_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [7:0]           sprite_tag,
    input  logic [15:0]          sprite_x,
    input  logic [15:0]          sprite_y,
    input  logic [15:0]          player_x,
    input  logic [15:0]          player_y,
    input  logic signed [15:0]   view_dir_x,
    input  logic signed [15:0]   view_dir_y,
    input  logic signed [15:0]   cam_plane_x,
    input  logic signed [15:0]   cam_plane_y,
    output logic                 done,
    output logic [7:0]           tag_out,
    output logic                 behind_camera,
    output logic [15:0]          depth,
    output logic signed [15:0]   screen_column,
    output logic [14:0]          sprite_size,
    output logic [11:0]          draw_top,
    output logic [11:0]          draw_bottom,
    output logic [14:0]          draw_left,
    output logic signed [15:0]   draw_right
);

    localparam int NWA  = NUM_W + VEC_FRAC_BITS;      // camera-space quotient width
    localparam int DFW  = NWA + 1;                    // |depth - lateral|
    localparam int LOW  = (DFW + 1) / 2;
    localparam int HIW  = DFW - LOW;
    localparam int PW   = 12 + DFW;                   // half width * difference
    localparam int LAT  = 2 + NWA + 3 + PW + 1;

    // configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: offsets and products
    logic signed [DX_W-1:0]   dx, dy;
    logic                     s1_valid_reg;
    logic [7:0]               s1_tag_reg;
    logic signed [DPRD_W-1:0] s1_det_a_reg, s1_det_b_reg;
    logic signed [PROD_W-1:0] s1_nx_a_reg, s1_nx_b_reg, s1_ny_a_reg, s1_ny_b_reg;

    assign dx = $signed({1'b0, sprite_x}) - $signed({1'b0, player_x});
    assign dy = $signed({1'b0, sprite_y}) - $signed({1'b0, player_y});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg   <= sprite_tag;
        s1_det_a_reg <= cam_plane_x * view_dir_y;
        s1_det_b_reg <= view_dir_x * cam_plane_y;
        s1_nx_a_reg  <= view_dir_y * dx;
        s1_nx_b_reg  <= view_dir_x * dy;
        s1_ny_a_reg  <= cam_plane_y * dx;
        s1_ny_b_reg  <= cam_plane_x * dy;
    end

    // stage 2: determinant and numerators
    logic                    s2_valid_reg;
    logic [7:0]              s2_tag_reg;
    logic signed [DET_W-1:0] s2_det_reg;
    logic signed [NUM_W-1:0] s2_numx_reg, s2_numy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_tag_reg  <= s1_tag_reg;
        s2_det_reg  <= DET_W'(s1_det_a_reg) - DET_W'(s1_det_b_reg);
        s2_numx_reg <= NUM_W'(s1_nx_a_reg) - NUM_W'(s1_nx_b_reg);
        s2_numy_reg <= NUM_W'(s1_ny_b_reg) - NUM_W'(s1_ny_a_reg);
    end

    // magnitudes into the camera-transform dividers
    logic [DET_W-1:0] det_mag;
    logic [NUM_W-1:0] numx_mag, numy_mag;
    logic [NWA-1:0]   lat_num, dep_num;
    logic             det_zero, lat_neg, dep_neg;

    always_comb
    begin
        det_mag  = s2_det_reg[DET_W-1] ? DET_W'(-s2_det_reg) : DET_W'(s2_det_reg);
        numx_mag = s2_numx_reg[NUM_W-1] ? NUM_W'(-s2_numx_reg) : NUM_W'(s2_numx_reg);
        numy_mag = s2_numy_reg[NUM_W-1] ? NUM_W'(-s2_numy_reg) : NUM_W'(s2_numy_reg);
        lat_num  = {numx_mag, {VEC_FRAC_BITS{1'b0}}};
        dep_num  = {numy_mag, {VEC_FRAC_BITS{1'b0}}};
        det_zero = (s2_det_reg == '0);
        lat_neg  = s2_numx_reg[NUM_W-1] ^ s2_det_reg[DET_W-1];
        dep_neg  = s2_numy_reg[NUM_W-1] ^ s2_det_reg[DET_W-1];
    end

    logic           da_valid;
    logic [NWA-1:0] lat_q, dep_q;
    logic [10:0]    da_side;
    logic           db_unused_valid;
    logic [1:0]     db_side;

    spp_div #(.NW(NWA), .DW(DET_W), .SW(11)) u_div_lat (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid_reg),
        .num      (lat_num),
        .den      (det_mag),
        .in_side  ({s2_tag_reg, det_zero, lat_neg, dep_neg}),
        .out_valid(da_valid),
        .quot     (lat_q),
        .out_side (da_side)
    );

    spp_div #(.NW(NWA), .DW(DET_W), .SW(2)) u_div_dep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid_reg),
        .num      (dep_num),
        .den      (det_mag),
        .in_side  ({lat_neg, dep_neg}),
        .out_valid(db_unused_valid),
        .quot     (dep_q),
        .out_side (db_side)
    );

    // stage 4: signed values, behind test, depth - lateral
    logic signed [NWA:0]   lat_s;
    logic signed [NWA+1:0] diff_s;
    logic                  behind_c;
    logic                  s4_valid_reg;
    logic [7:0]            s4_tag_reg;
    logic                  s4_behind_reg;
    logic [NWA-1:0]        s4_dep_reg;
    logic signed [NWA+1:0] s4_diff_reg;

    always_comb
    begin
        lat_s    = da_side[1] ? -$signed({1'b0, lat_q}) : $signed({1'b0, lat_q});
        diff_s   = $signed({2'b00, dep_q}) - $signed({lat_s[NWA], lat_s});
        // behind: zero determinant, depth not positive (zero quotient or negative sign), or side bits that disagree
        behind_c = da_side[2] || (dep_q == '0) || da_side[0]
                   || (db_side != {da_side[1], da_side[0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= da_valid && db_unused_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_tag_reg    <= da_side[10:3];
        s4_behind_reg <= behind_c;
        s4_dep_reg    <= dep_q;
        s4_diff_reg   <= diff_s;
    end

    // stage 5: partial products of half width times |diff|
    logic [DFW-1:0]    diff_mag;
    logic [11:0]       half_w;
    logic              s5_valid_reg;
    logic [7:0]        s5_tag_reg;
    logic              s5_behind_reg;
    logic              s5_neg_reg;
    logic [NWA-1:0]    s5_dep_reg;
    logic [12+LOW-1:0] s5_plo_reg;
    logic [12+HIW-1:0] s5_phi_reg;

    assign diff_mag = s4_diff_reg[NWA+1] ? DFW'(-s4_diff_reg) : DFW'(s4_diff_reg);
    assign half_w   = width_reg[CFG_W-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_tag_reg    <= s4_tag_reg;
        s5_behind_reg <= s4_behind_reg;
        s5_neg_reg    <= s4_diff_reg[NWA+1];
        s5_dep_reg    <= s4_dep_reg;
        s5_plo_reg    <= half_w * diff_mag[LOW-1:0];
        s5_phi_reg    <= half_w * diff_mag[DFW-1:LOW];
    end

    // stage 6: full product, saturated depth
    logic          s6_valid_reg;
    logic [7:0]    s6_tag_reg;
    logic          s6_behind_reg;
    logic          s6_neg_reg;
    logic [NWA-1:0] s6_dep_reg;
    logic [15:0]   s6_depth_reg;
    logic [PW-1:0] s6_prod_reg;
    logic [PW-1:0] size_num;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_tag_reg    <= s5_tag_reg;
        s6_behind_reg <= s5_behind_reg;
        s6_neg_reg    <= s5_neg_reg;
        s6_dep_reg    <= s5_dep_reg;
        s6_depth_reg  <= (s5_dep_reg > NWA'(16'hFFFF)) ? 16'hFFFF : s5_dep_reg[15:0];
        s6_prod_reg   <= (PW'(s5_phi_reg) << LOW) + PW'(s5_plo_reg);
    end

    assign size_num = PW'({height_reg, {POS_FRAC_BITS{1'b0}}});

    logic          dc_valid, dd_unused_valid;
    logic [PW-1:0] col_q, size_q;
    logic [8:0]    dc_side;
    logic [16:0]   dd_side;

    spp_div #(.NW(PW), .DW(NWA), .SW(9)) u_div_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s6_valid_reg),
        .num      (s6_prod_reg),
        .den      (s6_dep_reg),
        .in_side  ({s6_tag_reg, s6_neg_reg}),
        .out_valid(dc_valid),
        .quot     (col_q),
        .out_side (dc_side)
    );

    spp_div #(.NW(PW), .DW(NWA), .SW(17)) u_div_size (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s6_valid_reg),
        .num      (size_num),
        .den      (s6_dep_reg),
        .in_side  ({s6_behind_reg, s6_depth_reg}),
        .out_valid(dd_unused_valid),
        .quot     (size_q),
        .out_side (dd_side)
    );

    // final stage: clamp column and size, form draw bounds
    logic signed [15:0] col_c;
    logic [14:0]        size_c;
    logic [13:0]        hs;
    logic signed [17:0] hh_s, hs_s, col_s, h_s, w_s;
    logic signed [17:0] top_s, bot_s, left_s, right_s;
    logic [11:0]        top_c, bot_c;
    logic [14:0]        left_c;
    logic signed [15:0] right_c;
    logic               behind_f;

    always_comb
    begin
        behind_f = dd_side[16];
        if (!dc_side[0])
        begin
            col_c = (col_q > PW'(32767)) ? 16'sd32767 : $signed(col_q[15:0]);
        end
        else
        begin
            col_c = (col_q > PW'(32768)) ? -16'sd32768 : -$signed(col_q[15:0]);
        end
        size_c  = (size_q > PW'(32767)) ? 15'h7FFF : size_q[14:0];
        hs      = size_c[14:1];
        hh_s    = $signed({6'b0, height_reg[CFG_W-1:1]});
        hs_s    = $signed({4'b0, hs});
        col_s   = 18'(col_c);
        h_s     = $signed({5'b0, height_reg});
        w_s     = $signed({5'b0, width_reg});
        top_s   = hh_s - hs_s;
        top_c   = top_s[17] ? 12'd0 : top_s[11:0];
        bot_s   = hh_s + hs_s;
        if (bot_s >= h_s)
        begin
            bot_s = h_s - 18'sd1;
        end
        if (bot_s[17])
        begin
            bot_c = 12'd0;
        end
        else if (bot_s > 18'sd4095)
        begin
            bot_c = 12'hFFF;
        end
        else
        begin
            bot_c = bot_s[11:0];
        end
        left_s  = col_s - hs_s;
        left_c  = left_s[17] ? 15'd0 : left_s[14:0];
        right_s = col_s + hs_s;
        if (right_s >= w_s)
        begin
            right_s = w_s - 18'sd1;
        end
        right_c = right_s[15:0];
    end

    logic        done_reg;
    logic [7:0]  tag_reg;
    logic        behind_reg;
    logic [15:0] depth_reg;
    logic [15:0] column_reg;
    logic [14:0] size_reg;
    logic [11:0] top_reg, bottom_reg;
    logic [14:0] left_reg;
    logic [15:0] right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dc_valid && dd_unused_valid;
        end
    end

    // zero every geometric field when the sprite is behind the camera
    always_ff @(posedge clk)
    begin
        tag_reg    <= dc_side[8:1];
        behind_reg <= behind_f;
        depth_reg  <= behind_f ? 16'd0 : dd_side[15:0];
        column_reg <= behind_f ? 16'd0 : col_c;
        size_reg   <= behind_f ? 15'd0 : size_c;
        top_reg    <= behind_f ? 12'd0 : top_c;
        bottom_reg <= behind_f ? 12'd0 : bot_c;
        left_reg   <= behind_f ? 15'd0 : left_c;
        right_reg  <= behind_f ? 16'd0 : right_c;
    end

    assign done          = done_reg;
    assign tag_out       = tag_reg;
    assign behind_camera = behind_reg;
    assign depth         = depth_reg;
    assign screen_column = column_reg;
    assign sprite_size   = size_reg;
    assign draw_top      = top_reg;
    assign draw_bottom   = bottom_reg;
    assign draw_left     = left_reg;
    assign draw_right    = right_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result strobe missing after fixed latency");

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && behind_camera) |-> (depth == 16'd0 && sprite_size == 15'd0))
        else $error("behind-camera result carries geometry");

    a_depth_live: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !behind_camera) |-> (depth != 16'd0))
        else $error("visible sprite with zero depth");

    a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        (dc_valid == dd_unused_valid) && (da_valid == db_unused_valid))
        else $error("divider chains out of step");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the sprite screen projection unit.
module tb_top;
    import spp_pkg::*;

    localparam int LATENCY = 6 + 2 * (34 + 14) + 13;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [7:0]         tag;
        logic [15:0]        spr_x;
        logic [15:0]        spr_y;
        logic [15:0]        ply_x;
        logic [15:0]        ply_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] pln_x;
        logic signed [15:0] pln_y;
    } sprite_t;

    typedef struct {
        logic [7:0]         tag;
        logic               behind;
        logic [15:0]        dep;
        logic signed [15:0] col;
        logic [14:0]        size;
        logic [11:0]        top;
        logic [11:0]        bot;
        logic [14:0]        left;
        logic signed [15:0] right;
    } proj_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 start;
    logic                 busy;
    logic [7:0]           sprite_tag;
    logic [15:0]          sprite_x;
    logic [15:0]          sprite_y;
    logic [15:0]          player_x;
    logic [15:0]          player_y;
    logic signed [15:0]   view_dir_x;
    logic signed [15:0]   view_dir_y;
    logic signed [15:0]   cam_plane_x;
    logic signed [15:0]   cam_plane_y;
    logic                 done;
    logic [7:0]           tag_out;
    logic                 behind_camera;
    logic [15:0]          depth;
    logic signed [15:0]   screen_column;
    logic [14:0]          sprite_size;
    logic [11:0]          draw_top;
    logic [11:0]          draw_bottom;
    logic [14:0]          draw_left;
    logic signed [15:0]   draw_right;

    logic [CFG_W-1:0] scr_w;
    logic [CFG_W-1:0] scr_h;
    proj_t            pending_proj[$];
    int               errors;
    int               cycles;
    int               idle_pct;

    sprite_screen_projection_unit DUT (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint clampl(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic proj_t project(sprite_t s, logic [CFG_W-1:0] wr, logic [CFG_W-1:0] hr);
        proj_t  p;
        longint dx, dy, det, numx, numy, lat, dep, w, h, hw, hh, col, size, hs;
        longint top, bot, left, right;
        p = '{default: '0};
        p.tag = s.tag;
        dx = longint'(s.spr_x) - longint'(s.ply_x);
        dy = longint'(s.spr_y) - longint'(s.ply_y);
        det = longint'(s.pln_x) * longint'(s.dir_y) - longint'(s.dir_x) * longint'(s.pln_y);
        if (det == 0)
        begin
            p.behind = 1'b1;
            return p;
        end
        numx = longint'(s.dir_y) * dx - longint'(s.dir_x) * dy;
        numy = -longint'(s.pln_y) * dx + longint'(s.pln_x) * dy;
        lat = (numx * 16384) / det;
        dep = (numy * 16384) / det;
        if (dep <= 0)
        begin
            p.behind = 1'b1;
            return p;
        end
        w = longint'(wr);
        h = longint'(hr);
        hw = w / 2;
        hh = h / 2;
        col = clampl((hw * (dep - lat)) / dep, -32768, 32767);
        size = clampl((h * 256) / dep, 0, 32767);
        hs = size / 2;
        top = hh - hs;
        if (top < 0) top = 0;
        bot = hh + hs;
        if (bot >= h) bot = h - 1;
        bot = clampl(bot, 0, 4095);
        left = col - hs;
        if (left < 0) left = 0;
        right = col + hs;
        if (right >= w) right = w - 1;
        p.dep = 16'(clampl(dep, 0, 65535));
        p.col = col[15:0];
        p.size = size[14:0];
        p.top = top[11:0];
        p.bot = bot[11:0];
        p.left = left[14:0];
        p.right = right[15:0];
        return p;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Compare each result transfer with the oldest pending projection
    always @(posedge clk)
    begin
        proj_t e;
        if (rst_n && done)
        begin
            if (pending_proj.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, tag %0d", $time, tag_out);
            end
            else
            begin
                e = pending_proj.pop_front();
                check_field("tag_out", e.tag, tag_out);
                check_field("behind_camera", e.behind, behind_camera);
                check_field("depth", e.dep, depth);
                check_field("screen_column", e.col, screen_column);
                check_field("sprite_size", e.size, sprite_size);
                check_field("draw_top", e.top, draw_top);
                check_field("draw_bottom", e.bot, draw_bottom);
                check_field("draw_left", e.left, draw_left);
                check_field("draw_right", e.right, draw_right);
            end
        end
    end

    task automatic send_sprite(sprite_t s);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        start       <= 1'b1;
        sprite_tag  <= s.tag;
        sprite_x    <= s.spr_x;
        sprite_y    <= s.spr_y;
        player_x    <= s.ply_x;
        player_y    <= s.ply_y;
        view_dir_x  <= s.dir_x;
        view_dir_y  <= s.dir_y;
        cam_plane_x <= s.pln_x;
        cam_plane_y <= s.pln_y;
        do @(posedge clk); while (busy);
        pending_proj.push_back(project(s, scr_w, scr_h));
    endtask

    // Drop start and hold until every pending projection has come out
    task automatic drain;
        start <= 1'b0;
        wait (pending_proj.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SCREEN_WIDTH) scr_w = val;
        else scr_h = val;
    endtask

    function automatic logic [15:0] sat_pos(int v);
        return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    // Mostly a sane camera with the sprite nearby; the rest is raw noise
    function automatic sprite_t rand_sprite();
        sprite_t s;
        int a, b;
        s.tag   = 8'($urandom);
        s.ply_x = 16'($urandom);
        s.ply_y = 16'($urandom);
        s.spr_x = 16'($urandom);
        s.spr_y = 16'($urandom);
        s.dir_x = 16'($urandom);
        s.dir_y = 16'($urandom);
        s.pln_x = 16'($urandom);
        s.pln_y = 16'($urandom);
        if ($urandom_range(99) < 75)
        begin
            a = int'($urandom_range(32768)) - 16384;
            b = int'($urandom_range(32768)) - 16384;
            if (a == 0 && b == 0) a = 16384;
            s.dir_x = 16'(a);
            s.dir_y = 16'(b);
            s.pln_x = 16'((b * 43) / 64);
            s.pln_y = 16'(-(a * 43) / 64);
            s.spr_x = sat_pos(int'(s.ply_x) + int'($urandom_range(8192)) - 4096);
            s.spr_y = sat_pos(int'(s.ply_y) + int'($urandom_range(8192)) - 4096);
        end
        return s;
    endfunction

    task automatic test_directed;
        sprite_t s;
        s = '{8'd0, 16'h0280, 16'h0500, 16'h0280, 16'h0280,
              -16'sd16384, 16'sd0, 16'sd0, 16'sd10813};
        // zero determinant
        send_sprite('{8'd255, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_sprite('{8'd1, 16'd100, 16'd100, 16'd0, 16'd0,
                      16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
        // sprite on the player and sprite behind
        send_sprite('{8'd2, 16'h1000, 16'h1000, 16'h1000, 16'h1000,
                      16'sd16384, 16'sd0, 16'sd0, 16'sd10813});
        send_sprite('{8'd3, 16'h0800, 16'h1000, 16'h1000, 16'h1000,
                      16'sd16384, 16'sd0, 16'sd0, -16'sd10813});
        // sprite on the player, zero depth
        send_sprite('{8'd4, 16'h1000, 16'h1000, 16'h1000, 16'h1000,
                      16'sd16384, 16'sd0, 16'sd0, 16'sd32767});
        send_sprite(s);
        s.spr_y = 16'h0281;
        s.tag = 8'd5;
        send_sprite(s);
        s.spr_x = 16'hFFFF;
        s.tag = 8'd6;
        send_sprite(s);
        s.spr_x = 16'h0000;
        s.tag = 8'd7;
        send_sprite(s);
        // extreme vectors and positions
        send_sprite('{8'd8, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                      -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768});
        send_sprite('{8'd9, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                      16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767});
        send_sprite('{8'd10, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                      16'sd1, 16'sd0, 16'sd0, 16'sd1});
        send_sprite('{8'd11, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
                      16'sd1, -16'sd1, 16'sd1, 16'sd1});
        send_sprite('{8'd12, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000,
                      16'sd1, -16'sd1, 16'sd1, 16'sd1});
        drain();
    endtask

    task automatic test_random(int count);
        repeat (count) send_sprite(rand_sprite());
    endtask

    task automatic test_screen_sizes;
        logic [CFG_W-1:0] widths[6]  = '{13'd0, 13'd1, 13'd8191, 13'd4096, 13'd320, 13'd2};
        logic [CFG_W-1:0] heights[6] = '{13'd8191, 13'd0, 13'd1, 13'd4096, 13'd200, 13'd3};
        for (int i = 0; i < 6; i++)
        begin
            write_cfg(CFG_SCREEN_WIDTH, widths[i]);
            write_cfg(CFG_SCREEN_HEIGHT, heights[i]);
            test_random(40);
            drain();
        end
        write_cfg(CFG_SCREEN_WIDTH, SCREEN_WIDTH_RST);
        write_cfg(CFG_SCREEN_HEIGHT, SCREEN_HEIGHT_RST);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        errors = 0;
        idle_pct = 8;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        {sprite_tag, sprite_x, sprite_y, player_x, player_y} = '0;
        {view_dir_x, view_dir_y, cam_plane_x, cam_plane_y} = '0;
        scr_w = SCREEN_WIDTH_RST;
        scr_h = SCREEN_HEIGHT_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_screen_sizes();
        idle_pct = 8;
        test_random(450);
        drain();
        idle_pct = 74;
        test_random(450);
        drain();
        idle_pct = 0;
        test_random(500);
        drain();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sprite_screen_projection_unit.f
rtl/spp_pkg.sv
rtl/spp_div_cell.sv
rtl/spp_div.sv
rtl/sprite_screen_projection_unit.sv
tb/tb_top.sv
